/* sv/wkts_pkg.sv */
`default_nettype none
package wkts_pkg;

  localparam int ID_W   = 32;
  localparam int LVL_W  = 8;
  localparam int RAT_W  = 12;
  localparam int WANT_W = 4;
  localparam int ST_W   = 3;
  localparam int PAY_W  = ID_W + LVL_W + RAT_W;

  localparam logic [ST_W-1:0] ST_ADDED = 3'd0;
  localparam logic [ST_W-1:0] ST_DUP   = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 3'd2;
  localparam logic [ST_W-1:0] ST_MATCH = 3'd3;
  localparam logic [ST_W-1:0] ST_NONE  = 3'd4;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_ID,
    S_DECIDE,
    S_SCAN_D,
    S_DRAIN,
    S_RESP,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

/* sv/wkts_dist.sv */
`default_nettype none
module wkts_dist #(
  parameter int LM2W = 16,
  parameter int RM2W = 24,
  parameter int DW   = 41,
  parameter int XW   = 6,
  parameter logic [LM2W-1:0] LM2 = '0,
  parameter logic [RM2W-1:0] RM2 = '0
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_v,
  input  wire  [wkts_pkg::LVL_W-1:0]    self_lvl,
  input  wire  [wkts_pkg::RAT_W-1:0]    self_rat,
  input  wire  [wkts_pkg::PAY_W-1:0]    in_pay,
  input  wire  [XW-1:0]                 in_idx,
  output logic                          out_v,
  output logic [DW+XW-1:0]              out_dist,
  output logic [wkts_pkg::PAY_W-1:0]    out_pay
);

  localparam int LW = wkts_pkg::LVL_W;
  localparam int RW = wkts_pkg::RAT_W;
  localparam int PW = wkts_pkg::PAY_W;

  logic          v1_r, v2_r;
  logic [2*RW-1:0] dr2_r;
  logic [2*LW-1:0] dl2_r;
  logic [2*RW+LM2W-1:0] pr_r;
  logic [2*LW+RM2W-1:0] pl_r;
  logic [PW-1:0] p1_r, p2_r;
  logic [XW-1:0] i1_r, i2_r;
  logic [RW-1:0] rat, dr;
  logic [LW-1:0] lvl, dl;

  assign lvl = in_pay[wkts_pkg::ID_W +: LW];
  assign rat = in_pay[wkts_pkg::ID_W+LW +: RW];
  assign dr  = (rat > self_rat) ? (rat - self_rat) : (self_rat - rat);
  assign dl  = (lvl > self_lvl) ? (lvl - self_lvl) : (self_lvl - lvl);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      v1_r  <= in_v;
      v2_r  <= v1_r;
      out_v <= v2_r;
    end
    dr2_r    <= (2*RW)'(dr) * (2*RW)'(dr);
    dl2_r    <= (2*LW)'(dl) * (2*LW)'(dl);
    p1_r     <= in_pay;
    i1_r     <= in_idx;
    pr_r     <= (2*RW+LM2W)'(dr2_r) * (2*RW+LM2W)'(LM2);
    pl_r     <= (2*LW+RM2W)'(dl2_r) * (2*LW+RM2W)'(RM2);
    p2_r     <= p1_r;
    i2_r     <= i1_r;
    // slot index in the low bits breaks distance ties toward the lower slot
    out_dist <= {DW'(pr_r) + DW'(pl_r), i2_r};
    out_pay  <= p2_r;
  end

endmodule
`default_nettype wire

/* sv/wkts_cell.sv */
`default_nettype none
module wkts_cell #(
  parameter int DW = 41
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         clr,
  input  wire                         shift,
  input  wire                         in_v,
  input  wire  [DW-1:0]               in_dist,
  input  wire  [wkts_pkg::PAY_W-1:0]  in_pay,
  input  wire                         nb_v,
  input  wire  [wkts_pkg::PAY_W-1:0]  nb_pay,
  output logic                        pass_v_r,
  output logic [DW-1:0]               pass_dist_r,
  output logic [wkts_pkg::PAY_W-1:0]  pass_pay_r,
  output logic                        hold_v_r,
  output logic [wkts_pkg::PAY_W-1:0]  hold_pay_r
);

  logic [DW-1:0] hold_dist_r;
  logic          take;

  // keep the smaller, pass the larger; ties stay put so lower slots win
  assign take = in_v && (!hold_v_r || (in_dist < hold_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      hold_v_r <= 1'b0;
      pass_v_r <= 1'b0;
    end else if (shift) begin
      hold_v_r <= nb_v;
      pass_v_r <= 1'b0;
    end else begin
      pass_v_r <= in_v && (!take || hold_v_r);
      if (take) hold_v_r <= 1'b1;
    end
    if (shift) begin
      hold_pay_r <= nb_pay;
    end else if (take) begin
      hold_dist_r <= in_dist;
      hold_pay_r  <= in_pay;
      pass_dist_r <= hold_dist_r;
      pass_pay_r  <= hold_pay_r;
    end else begin
      pass_dist_r <= in_dist;
      pass_pay_r  <= in_pay;
    end
  end

endmodule
`default_nettype wire

/* sv/weighted_knn_table_search.sv */
`default_nettype none
// Add: accept, id scan over the fill_count table entries, decide, one result beat.
// Query: same id scan and decide; if the id is found, want_count is nonzero and the table
// holds two or more entries, a distance scan into the cell chain, a drain, then one beat
// per result; otherwise one status beat. One item at a time.
// Synchronous active-low reset clears the fill count and control; table contents
// are not cleared.
module weighted_knn_table_search #(
  parameter int TABLE_DEPTH = 64,
  parameter int MAX_RESULTS = 8,
  parameter int RATING_MAX  = 4095,
  parameter int LEVEL_MAX   = 255
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [55:0] in_tdata,  // player_id[31:0], level[39:32], rating[51:40], want_count[55:52]
  input  wire  [0:0]  in_tuser,  // op
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [55:0] out_tdata, // match_id[31:0], match_level[39:32], match_rating[51:40]
  output logic [2:0]  out_tuser, // status
  output logic        out_tlast
);

  localparam int IW   = wkts_pkg::ID_W;
  localparam int LW   = wkts_pkg::LVL_W;
  localparam int RW   = wkts_pkg::RAT_W;
  localparam int PW   = wkts_pkg::PAY_W;
  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int FW   = $clog2(TABLE_DEPTH + 1);
  localparam int CW   = $clog2(MAX_RESULTS + 1);
  localparam int LM2W = 2 * $clog2(LEVEL_MAX + 1);
  localparam int RM2W = 2 * $clog2(RATING_MAX + 1);
  localparam int DWA  = 2 * RW + LM2W;
  localparam int DWB  = 2 * LW + RM2W;
  localparam int DW   = ((DWA > DWB) ? DWA : DWB) + 1;
  localparam int KW   = DW + AW;
  localparam int DRAIN = MAX_RESULTS + 8;
  localparam int DRW  = $clog2(DRAIN + 1);
  localparam logic [LM2W-1:0] LM2 = LM2W'(64'(LEVEL_MAX) * 64'(LEVEL_MAX));
  localparam logic [RM2W-1:0] RM2 = RM2W'(64'(RATING_MAX) * 64'(RATING_MAX));

  logic [IW-1:0] mem_id  [TABLE_DEPTH];
  logic [LW-1:0] mem_lvl [TABLE_DEPTH];
  logic [RW-1:0] mem_rat [TABLE_DEPTH];

  wkts_pkg::state_t state_r, state_nxt;
  logic [FW-1:0]  fill_r, idx_r;
  logic [DRW-1:0] drain_r;
  logic [CW-1:0]  want_r, n_r, emit_r;
  logic           op_r, found_r, rd_v_r;
  logic [IW-1:0]  key_r;
  logic [LW-1:0]  key_lvl_r, self_lvl_r;
  logic [RW-1:0]  key_rat_r, self_rat_r;
  logic [AW-1:0]  self_r, rd_idx_r;
  logic [IW-1:0]  rd_id_r;
  logic [LW-1:0]  rd_lvl_r;
  logic [RW-1:0]  rd_rat_r;
  logic [2:0]     status_r, status_nxt;
  logic           issue, scan_done, in_acc, out_acc, shift, clr;
  logic [7:0]     w8;

  logic          c_in_v  [MAX_RESULTS+1];
  logic [KW-1:0] c_in_d  [MAX_RESULTS+1];
  logic [PW-1:0] c_in_p  [MAX_RESULTS+1];
  logic          c_hold_v[MAX_RESULTS+1];
  logic [PW-1:0] c_hold_p[MAX_RESULTS+1];
  logic          d_v;

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign issue     = ((state_r == wkts_pkg::S_SCAN_ID) || (state_r == wkts_pkg::S_SCAN_D))
                     && (idx_r < fill_r);
  assign scan_done = (idx_r >= fill_r) && !rd_v_r;
  assign shift     = (state_r == wkts_pkg::S_EMIT) && out_acc;
  assign clr       = (state_r == wkts_pkg::S_DECIDE);
  assign w8        = 8'(in_tdata[55:52]);

  always_comb begin
    status_nxt = wkts_pkg::ST_NONE;
    if (op_r == wkts_pkg::OP_ADD) begin
      if (found_r) status_nxt = wkts_pkg::ST_DUP;
      else if (fill_r >= FW'(TABLE_DEPTH)) status_nxt = wkts_pkg::ST_FULL;
      else status_nxt = wkts_pkg::ST_ADDED;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wkts_pkg::S_IDLE:    if (in_acc) state_nxt = wkts_pkg::S_SCAN_ID;
      wkts_pkg::S_SCAN_ID: if (scan_done) state_nxt = wkts_pkg::S_DECIDE;
      wkts_pkg::S_DECIDE: begin
        if (op_r == wkts_pkg::OP_ADD || !found_r || want_r == '0 || fill_r < FW'(2))
          state_nxt = wkts_pkg::S_RESP;
        else
          state_nxt = wkts_pkg::S_SCAN_D;
      end
      wkts_pkg::S_SCAN_D:  if (idx_r >= fill_r) state_nxt = wkts_pkg::S_DRAIN;
      wkts_pkg::S_DRAIN:   if (drain_r == DRW'(DRAIN)) state_nxt = wkts_pkg::S_EMIT;
      wkts_pkg::S_RESP:    if (out_acc) state_nxt = wkts_pkg::S_IDLE;
      wkts_pkg::S_EMIT:    if (out_acc && emit_r == n_r - CW'(1)) state_nxt = wkts_pkg::S_IDLE;
      default:             state_nxt = wkts_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == wkts_pkg::S_IDLE);
    out_tvalid = (state_r == wkts_pkg::S_RESP) || (state_r == wkts_pkg::S_EMIT);
    out_tuser  = status_r;
    out_tdata  = '0;
    out_tlast  = 1'b1;
    if (state_r == wkts_pkg::S_EMIT) begin
      out_tuser = wkts_pkg::ST_MATCH;
      out_tdata = 56'(c_hold_p[0]);
      out_tlast = (emit_r == n_r - CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wkts_pkg::S_IDLE;
      fill_r  <= '0;
      rd_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      if (clr && status_nxt == wkts_pkg::ST_ADDED) fill_r <= fill_r + FW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_id_r  <= mem_id[idx_r[AW-1:0]];
      rd_lvl_r <= mem_lvl[idx_r[AW-1:0]];
      rd_rat_r <= mem_rat[idx_r[AW-1:0]];
    end
    rd_idx_r <= idx_r[AW-1:0];
    if (clr && status_nxt == wkts_pkg::ST_ADDED) begin
      mem_id[fill_r[AW-1:0]]  <= key_r;
      mem_lvl[fill_r[AW-1:0]] <= key_lvl_r;
      mem_rat[fill_r[AW-1:0]] <= key_rat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_tuser[0];
      key_r     <= in_tdata[31:0];
      key_lvl_r <= in_tdata[39:32];
      key_rat_r <= in_tdata[51:40];
      want_r    <= (w8 > 8'(MAX_RESULTS)) ? CW'(MAX_RESULTS) : CW'(w8);
      found_r   <= 1'b0;
      idx_r     <= '0;
    end else if (issue) begin
      idx_r <= idx_r + FW'(1);
    end
    if (state_r == wkts_pkg::S_SCAN_ID && rd_v_r && !found_r && rd_id_r == key_r) begin
      found_r    <= 1'b1;
      self_r     <= rd_idx_r;
      self_lvl_r <= rd_lvl_r;
      self_rat_r <= rd_rat_r;
    end
    if (clr) begin
      status_r <= status_nxt;
      idx_r    <= '0;
      drain_r  <= '0;
      emit_r   <= '0;
      n_r      <= (16'(want_r) < 16'(fill_r) - 16'd1) ? want_r : CW'(fill_r - FW'(1));
    end
    if (state_r == wkts_pkg::S_DRAIN) drain_r <= drain_r + DRW'(1);
    if (shift) emit_r <= emit_r + CW'(1);
  end

  assign d_v = (state_r == wkts_pkg::S_SCAN_D || state_r == wkts_pkg::S_DRAIN)
               && rd_v_r && (rd_idx_r != self_r);

  wkts_dist #(
    .LM2W(LM2W), .RM2W(RM2W), .DW(DW), .XW(AW), .LM2(LM2), .RM2(RM2)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (d_v),
    .self_lvl (self_lvl_r),
    .self_rat (self_rat_r),
    .in_pay   ({rd_rat_r, rd_lvl_r, rd_id_r}),
    .in_idx   (rd_idx_r),
    .out_v    (c_in_v[0]),
    .out_dist (c_in_d[0]),
    .out_pay  (c_in_p[0])
  );

  assign c_hold_v[MAX_RESULTS] = 1'b0;
  assign c_hold_p[MAX_RESULTS] = '0;

  for (genvar g = 0; g < MAX_RESULTS; g++) begin : g_cell
    wkts_cell #(.DW(KW)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .clr         (clr),
      .shift       (shift),
      .in_v        (c_in_v[g]),
      .in_dist     (c_in_d[g]),
      .in_pay      (c_in_p[g]),
      .nb_v        (c_hold_v[g+1]),
      .nb_pay      (c_hold_p[g+1]),
      .pass_v_r    (c_in_v[g+1]),
      .pass_dist_r (c_in_d[g+1]),
      .pass_pay_r  (c_in_p[g+1]),
      .hold_v_r    (c_hold_v[g]),
      .hold_pay_r  (c_hold_p[g])
    );
  end

endmodule
`default_nettype wire

/* tb/tb_top.sv */
module tb_top;

  localparam int DEPTH = 64;
  localparam int MAXR  = 8;
  localparam int LMAX  = 255;
  localparam int RMAX  = 4095;

  typedef struct packed {
    logic [wkts_pkg::ST_W-1:0]  status;
    logic [wkts_pkg::ID_W-1:0]  id;
    logic [wkts_pkg::LVL_W-1:0] lvl;
    logic [wkts_pkg::RAT_W-1:0] rat;
    logic                       last;
  } match_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  logic [wkts_pkg::ID_W-1:0]  tbl_id  [DEPTH];
  logic [wkts_pkg::LVL_W-1:0] tbl_lvl [DEPTH];
  logic [wkts_pkg::RAT_W-1:0] tbl_rat [DEPTH];
  int                         tbl_fill;

  match_t expected_q[$];
  int     n_mismatch;
  int     n_beats;
  int     n_items;
  int     n_queries;
  bit     stall_en;

  weighted_knn_table_search DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int find_entry(logic [wkts_pkg::ID_W-1:0] id);
    for (int i = 0; i < tbl_fill; i++)
      if (tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic longint unsigned knn_dist(int a, int b);
    longint unsigned dr;
    longint unsigned dl;
    dr = tbl_rat[a] > tbl_rat[b] ? tbl_rat[a] - tbl_rat[b] : tbl_rat[b] - tbl_rat[a];
    dl = tbl_lvl[a] > tbl_lvl[b] ? tbl_lvl[a] - tbl_lvl[b] : tbl_lvl[b] - tbl_lvl[a];
    return dr * dr * LMAX * LMAX + dl * dl * RMAX * RMAX;
  endfunction

  function automatic void push_status(logic [wkts_pkg::ST_W-1:0] st);
    match_t m;
    m = '{status: st, id: '0, lvl: '0, rat: '0, last: 1'b1};
    expected_q.insert(expected_q.size(), m);
  endfunction

  task automatic predict_knn(logic op, logic [wkts_pkg::ID_W-1:0] id,
                             logic [wkts_pkg::LVL_W-1:0] lvl,
                             logic [wkts_pkg::RAT_W-1:0] rat,
                             logic [wkts_pkg::WANT_W-1:0] want);
    int self;
    int best;
    int n;
    int w;
    longint unsigned bd;
    longint unsigned d;
    bit used [DEPTH];
    match_t m;
    if (op == wkts_pkg::OP_ADD) begin
      if (find_entry(id) >= 0) push_status(wkts_pkg::ST_DUP);
      else if (tbl_fill >= DEPTH) push_status(wkts_pkg::ST_FULL);
      else begin
        tbl_id[tbl_fill] = id;
        tbl_lvl[tbl_fill] = lvl;
        tbl_rat[tbl_fill] = rat;
        tbl_fill++;
        push_status(wkts_pkg::ST_ADDED);
      end
      return;
    end
    n_queries++;
    self = find_entry(id);
    if (self < 0 || want == 0 || tbl_fill < 2) begin
      push_status(wkts_pkg::ST_NONE);
      return;
    end
    w = want > MAXR ? MAXR : want;
    foreach (used[i]) used[i] = 1'b0;
    used[self] = 1'b1;
    n = 0;
    for (int k = 0; k < w; k++) begin
      best = -1;
      bd = 0;
      for (int i = 0; i < tbl_fill; i++) begin
        if (used[i]) continue;
        d = knn_dist(self, i);
        if (best < 0 || d < bd) begin
          best = i;
          bd = d;
        end
      end
      if (best < 0) break;
      used[best] = 1'b1;
      m = '{status: wkts_pkg::ST_MATCH, id: tbl_id[best], lvl: tbl_lvl[best],
            rat: tbl_rat[best], last: (k == w - 1) || (n == tbl_fill - 2)};
      expected_q.insert(expected_q.size(), m);
      n++;
    end
  endtask

  task automatic send_item(logic op, logic [wkts_pkg::ID_W-1:0] id,
                           logic [wkts_pkg::LVL_W-1:0] lvl,
                           logic [wkts_pkg::RAT_W-1:0] rat,
                           logic [wkts_pkg::WANT_W-1:0] want);
    int gap;
    gap = stall_en ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {want, rat, lvl, id};
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_knn(op, id, lvl, rat, want);
    n_items++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int wait_n;
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      wait_n = stall_en ? $urandom_range(0, 17) : 0;
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid && out_tready));
    end
  end

  always @(posedge clk) begin
    match_t got;
    match_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      n_beats++;
      got = '{status: out_tuser, id: out_tdata[31:0], lvl: out_tdata[39:32],
              rat: out_tdata[51:40], last: out_tlast};
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected beat %p", got);
      end else begin
        exp = expected_q.pop_front();
        if (got !== exp) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("mismatch: expected %p actual %p", exp, got);
        end
      end
    end
  end

  task automatic test_directed();
    send_item(wkts_pkg::OP_QUERY, 32'h1, 8'h0, 12'h0, 4'd3);
    send_item(wkts_pkg::OP_ADD, 32'h0, 8'h00, 12'h000, 4'd0);
    send_item(wkts_pkg::OP_QUERY, 32'h0, 8'h00, 12'h000, 4'd5);
    send_item(wkts_pkg::OP_ADD, 32'hFFFF_FFFF, 8'hFF, 12'hFFF, 4'hF);
    send_item(wkts_pkg::OP_ADD, 32'hFFFF_FFFF, 8'h12, 12'h345, 4'd1);
    send_item(wkts_pkg::OP_ADD, 32'hA5A5_5A5A, 8'h80, 12'h800, 4'd2);
    send_item(wkts_pkg::OP_ADD, 32'h5A5A_A5A5, 8'h80, 12'h800, 4'd2);
    send_item(wkts_pkg::OP_ADD, 32'h0000_0010, 8'h7F, 12'h7FF, 4'd2);
    send_item(wkts_pkg::OP_QUERY, 32'h0, 8'hFF, 12'hFFF, 4'd0);
    send_item(wkts_pkg::OP_QUERY, 32'h0, 8'h0, 12'h0, 4'd15);
    send_item(wkts_pkg::OP_QUERY, 32'hA5A5_5A5A, 8'h0, 12'h0, 4'd2);
    send_item(wkts_pkg::OP_QUERY, 32'hFFFF_FFFF, 8'h0, 12'h0, 4'd8);
    send_item(wkts_pkg::OP_QUERY, 32'h1234_5678, 8'h0, 12'h0, 4'd4);
    wait_drained();
  endtask

  task automatic test_fill_table();
    logic [wkts_pkg::ID_W-1:0] id;
    while (tbl_fill < DEPTH) begin
      id = $urandom_range(0, 3) == 0 ? 32'($urandom_range(0, 200)) : $urandom;
      send_item(wkts_pkg::OP_ADD, id, 8'($urandom_range(0, 3) == 0 ? 255 : $urandom),
                12'($urandom), 4'($urandom));
      if ($urandom_range(0, 4) == 0)
        send_item(wkts_pkg::OP_QUERY, tbl_id[$urandom_range(0, tbl_fill - 1)],
                  8'($urandom), 12'($urandom), 4'($urandom));
    end
    send_item(wkts_pkg::OP_ADD, 32'hDEAD_BEEF, 8'h1, 12'h1, 4'd1);
    send_item(wkts_pkg::OP_ADD, tbl_id[3], 8'h1, 12'h1, 4'd1);
    wait_drained();
  endtask

  task automatic test_random_queries();
    logic [wkts_pkg::ID_W-1:0] id;
    repeat (150) begin
      id = $urandom_range(0, 9) == 0 ? $urandom : tbl_id[$urandom_range(0, DEPTH - 1)];
      send_item($urandom_range(0, 9) == 0 ? wkts_pkg::OP_ADD : wkts_pkg::OP_QUERY, id,
                8'($urandom), 12'($urandom), 4'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    tbl_fill = 0;
    n_mismatch = 0;
    n_beats = 0;
    n_items = 0;
    n_queries = 0;
    stall_en = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    stall_en = 1'b1;
    test_fill_table();
    test_random_queries();
    stall_en = 1'b0;
    repeat (20)
      send_item(wkts_pkg::OP_QUERY, tbl_id[$urandom_range(0, DEPTH - 1)], 8'h0, 12'h0,
                4'($urandom));
    wait_drained();
    $display("covered %0d items (%0d queries), %0d result beats, table filled to %0d",
             n_items, n_queries, n_beats, tbl_fill);
    if (n_mismatch == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d beats missing", n_mismatch, expected_q.size());
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
